// ===== src/dfvr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfvr_pkg
// Shared types and codes for the direction frame vertex rotate block.
// ----------------------------------------------------------------------------
`default_nettype none

package dfvr_pkg;

	localparam int unsigned PosW   = 24;
	localparam int unsigned CoefW  = 16;
	localparam int unsigned CfgIdxW = 3;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_Z_DIR_X  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_Z_DIR_Y  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_Z_DIR_Z  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_X_DIR_X  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_X_DIR_Y  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_X_DIR_Z  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_FRAME_MODE = 3'd6;

	typedef struct packed {
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [PosW-1:0] pos_z;
	} pos_t;

	typedef struct packed {
		logic signed [PosW-1:0] out_x;
		logic signed [PosW-1:0] out_y;
		logic signed [PosW-1:0] out_z;
		logic                   degenerate;
	} res_t;

	// basis in Q1.14: x axis in 0..2, y axis in 3..5, z axis in 6..8
	typedef struct packed {
		logic [8:0][CoefW-1:0] mat;
		logic                  ready;
		logic                  bad;
	} basis_t;

endpackage

`default_nettype wire

// ===== src/dfvr_basis.sv =====
// ----------------------------------------------------------------------------
// dfvr_basis
// Configuration registers and the sequencer that builds the Q1.14 frame:
// squared length, bit-serial square root, restoring division per component,
// then the cross product through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvr_basis (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dfvr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [dfvr_pkg::CoefW-1:0]     cfg_wdata,
	output dfvr_pkg::basis_t                    basis
);
	import dfvr_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_LEN   = 8'b00000010,
		ST_SQRT  = 8'b00000100,
		ST_DIVLD = 8'b00001000,
		ST_DIV   = 8'b00010000,
		ST_NEXT  = 8'b00100000,
		ST_CROSS = 8'b01000000,
		ST_FAIL  = 8'b10000000
	} state_t;

	localparam logic [5:0] DivLast = 6'd44;

	state_t state_q;

	logic signed [15:0] zx_q, zy_q, zz_q, xx_q, xy_q, xz_q;
	logic               mode_q;

	logic signed [16:0] v_q [3];
	logic               phase_q;
	logic [2:0]         step_q;
	logic [1:0]         comp_q;
	logic [5:0]         cnt_q;
	logic signed [34:0] acc_q;
	logic [59:0]        n_q, root_q, bit_q;
	logic [30:0]        s_q;
	logic [44:0]        dvd_q, quo_q;
	logic [30:0]        rem_q;
	logic signed [15:0] o_q [3];
	logic signed [15:0] zn_q [3];
	logic signed [15:0] xn_q [3];
	logic signed [15:0] y_q [3];
	logic [8:0][15:0]   mat_q;
	logic               ready_q, bad_q;

	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod;
	logic signed [34:0] acc_sum;
	logic [31:0]        len2;
	logic [59:0]        sq_t;
	logic               sq_ge;
	logic [31:0]        div_r2;
	logic               div_ge;
	logic [44:0]        quo_n;
	logic [15:0]        q_sat;
	logic [16:0]        m_abs;
	logic               cfg_hit;

	function automatic logic signed [15:0] rnd14_sat16(input logic signed [34:0] a);
		logic [34:0] mag;
		logic [20:0] r;
		logic signed [15:0] res;
		mag = a[34] ? 35'(-a) : 35'(a);
		r = 21'((mag + 35'd8192) >> 14);
		if (a[34]) begin
			res = (r > 21'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, r}));
		end else begin
			res = (r > 21'd32767) ? 16'sd32767 : 16'(r);
		end
		return res;
	endfunction

	always_comb begin
		mul_a = v_q[step_q[1:0]];
		mul_b = v_q[step_q[1:0]];
		if (state_q == ST_CROSS) begin
			case (step_q)
				3'd0: begin mul_a = 17'(zn_q[1]); mul_b = 17'(xn_q[2]); end
				3'd1: begin mul_a = 17'(zn_q[2]); mul_b = 17'(xn_q[1]); end
				3'd2: begin mul_a = 17'(zn_q[2]); mul_b = 17'(xn_q[0]); end
				3'd3: begin mul_a = 17'(zn_q[0]); mul_b = 17'(xn_q[2]); end
				3'd4: begin mul_a = 17'(zn_q[0]); mul_b = 17'(xn_q[1]); end
				3'd5: begin mul_a = 17'(zn_q[1]); mul_b = 17'(xn_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign prod    = mul_a * mul_b;
	assign acc_sum = acc_q + 35'(prod);
	assign len2    = acc_sum[31:0];

	assign sq_t  = root_q + bit_q;
	assign sq_ge = (n_q >= sq_t);

	assign div_r2 = {rem_q, dvd_q[44]};
	assign div_ge = (div_r2 >= {1'b0, s_q});
	assign quo_n  = {quo_q[43:0], div_ge};
	assign q_sat  = (quo_n > 45'd16384) ? 16'd16384 : quo_n[15:0];
	assign m_abs  = v_q[comp_q][16] ? 17'(-v_q[comp_q]) : 17'(v_q[comp_q]);

	assign cfg_hit = cfg_we && (cfg_index <= REG_FRAME_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			zx_q <= 16'sd0; zy_q <= 16'sd0; zz_q <= 16'sd1;
			xx_q <= 16'sd1; xy_q <= 16'sd0; xz_q <= 16'sd0;
			mode_q <= 1'b0;
			mat_q <= '0;
			ready_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_Z_DIR_X: zx_q <= cfg_wdata;
				REG_Z_DIR_Y: zy_q <= cfg_wdata;
				REG_Z_DIR_Z: zz_q <= cfg_wdata;
				REG_X_DIR_X: xx_q <= cfg_wdata;
				REG_X_DIR_Y: xy_q <= cfg_wdata;
				REG_X_DIR_Z: xz_q <= cfg_wdata;
				default:     mode_q <= cfg_wdata[0];
			endcase
			ready_q <= 1'b0;
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!ready_q) begin
						v_q[0] <= 17'(zx_q); v_q[1] <= 17'(zy_q); v_q[2] <= 17'(zz_q);
						phase_q <= 1'b0;
						step_q <= '0;
						acc_q <= '0;
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					acc_q <= acc_sum;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						if (len2 == 32'd0) begin
							state_q <= ST_FAIL;
						end else begin
							n_q <= {len2, 28'd0};
							root_q <= '0;
							bit_q <= 60'd1 << 58;
							state_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (sq_ge) begin
						n_q <= n_q - sq_t;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 60'd1) begin
						s_q <= sq_ge ? 31'((root_q >> 1) + bit_q) : 31'(root_q >> 1);
						comp_q <= '0;
						state_q <= ST_DIVLD;
					end
				end
				ST_DIVLD: begin
					dvd_q <= {m_abs, 28'd0} + {15'd0, s_q[30:1]};
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= div_ge ? 31'(div_r2 - {1'b0, s_q}) : div_r2[30:0];
					dvd_q <= {dvd_q[43:0], 1'b0};
					quo_q <= quo_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DivLast) begin
						o_q[comp_q] <= v_q[comp_q][16] ? -$signed(q_sat) : $signed(q_sat);
						if (comp_q == 2'd2) begin
							state_q <= ST_NEXT;
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= ST_DIVLD;
						end
					end
				end
				ST_NEXT: begin
					step_q <= '0;
					acc_q <= '0;
					if (phase_q) begin
						xn_q <= o_q;
						state_q <= ST_CROSS;
					end else begin
						zn_q <= o_q;
						phase_q <= 1'b1;
						if (mode_q) begin
							v_q[0] <= 17'(xx_q); v_q[1] <= 17'(xy_q); v_q[2] <= 17'(xz_q);
							state_q <= ST_LEN;
						end else if (o_q[0] == 16'sd0 && o_q[1] == 16'sd0) begin
							xn_q[0] <= o_q[2];
							xn_q[1] <= 16'sd0;
							xn_q[2] <= 16'sd0;
							state_q <= ST_CROSS;
						end else begin
							v_q[0] <= -17'(o_q[1]); v_q[1] <= 17'(o_q[0]); v_q[2] <= 17'sd0;
							state_q <= ST_LEN;
						end
					end
				end
				ST_CROSS: begin
					// even steps start a component, odd steps subtract the second term
					if (step_q[0]) begin
						acc_q <= acc_q - 35'(prod);
					end else begin
						acc_q <= 35'(prod);
					end
					if (step_q != 3'd0 && !step_q[0]) begin
						y_q[step_q[2:1] - 2'd1] <= rnd14_sat16(acc_q);
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						mat_q[0] <= xn_q[0]; mat_q[1] <= xn_q[1]; mat_q[2] <= xn_q[2];
						mat_q[3] <= y_q[0];  mat_q[4] <= y_q[1];
						mat_q[5] <= rnd14_sat16(acc_q);
						mat_q[6] <= zn_q[0]; mat_q[7] <= zn_q[1]; mat_q[8] <= zn_q[2];
						bad_q <= 1'b0;
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FAIL: begin
					mat_q <= '0;
					bad_q <= 1'b1;
					ready_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign basis.mat   = mat_q;
	assign basis.ready = ready_q;
	assign basis.bad   = bad_q;

	a_cfg_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !ready_q)
		else $error("basis still ready after a register write");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q && bad_q) |-> (mat_q == '0))
		else $error("degenerate basis is not zero");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ready_q)
		else $error("basis ready while the sequencer runs");

endmodule

`default_nettype wire

// ===== src/direction_frame_vertex_rotate.sv =====
// ----------------------------------------------------------------------------
// direction_frame_vertex_rotate
// Maps Q12.12 points into a frame built from the direction regs (orthonormal when x is derived).
// ----------------------------------------------------------------------------
// After reset or a write to register index 0 to 6 the frame is rebuilt by a
// serial sequencer (start, then squared length, square root and per-component
// division for each of one or two vectors, then the cross product); pos_stall
// stays high until it is done. Then one point is taken every cycle unless the
// output stalls; stages: nine 24x16 products, a row sum, rounding/saturation.
`default_nettype none

module direction_frame_vertex_rotate (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pos_valid,
	output logic                               pos_stall,
	input  dfvr_pkg::pos_t                     pos_data,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output dfvr_pkg::res_t                     res_data,
	input  wire logic                          cfg_we,
	input  wire logic [dfvr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [dfvr_pkg::CoefW-1:0]    cfg_wdata
);
	import dfvr_pkg::*;

	basis_t basis;

	logic               advance;
	logic               take;
	logic               v_s1, v_s2, v_s3;
	logic               deg_s1, deg_s2;
	logic signed [39:0] prod_s1 [9];
	logic signed [41:0] sum_s2 [3];
	res_t               res_s3;
	logic signed [23:0] row_out [3];

	dfvr_basis u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.basis     (basis)
	);

	function automatic logic signed [23:0] rnd14_sat24(input logic signed [41:0] a);
		logic [41:0] mag;
		logic [27:0] r;
		logic signed [23:0] res;
		mag = a[41] ? 42'(-a) : 42'(a);
		r = 28'((mag + 42'd8192) >> 14);
		if (a[41]) begin
			res = (r > 28'd8388608) ? -24'sd8388608 : 24'(-$signed({1'b0, r}));
		end else begin
			res = (r > 28'd8388607) ? 24'sd8388607 : 24'(r);
		end
		return res;
	endfunction

	assign advance   = !(v_s3 && res_stall);
	assign pos_stall = !advance || !basis.ready;
	assign take      = pos_valid && !pos_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r]     <= pos_data.pos_x * $signed(basis.mat[r]);
				prod_s1[3 + r] <= pos_data.pos_y * $signed(basis.mat[3 + r]);
				prod_s1[6 + r] <= pos_data.pos_z * $signed(basis.mat[6 + r]);
			end
			deg_s1 <= basis.bad;
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= 42'(prod_s1[r]) + 42'(prod_s1[3 + r]) + 42'(prod_s1[6 + r]);
			end
			deg_s2 <= deg_s1;
			res_s3.out_x      <= row_out[0];
			res_s3.out_y      <= row_out[1];
			res_s3.out_z      <= row_out[2];
			res_s3.degenerate <= deg_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_out[r] = rnd14_sat24(sum_s2[r]);
		end
	end

	assign res_valid = v_s3;
	assign res_data  = res_s3;

	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && !pos_stall) |-> basis.ready)
		else $error("point taken before the frame was built");

	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s2) |=> v_s3)
		else $error("item lost between row sum and output");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.degenerate) |->
		(res_data.out_x == '0 && res_data.out_y == '0 && res_data.out_z == '0))
		else $error("degenerate frame gave a nonzero result");

endmodule

`default_nettype wire

// ===== test/dfvr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfvr_checker
// Watches the point and result channels and the register port, keeps its own
// copy of the frame registers, predicts each rotated point and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvr_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pos_valid,
	input  wire logic                          pos_stall,
	input  dfvr_pkg::pos_t                     pos_data,
	input  wire logic                          res_valid,
	input  wire logic                          res_stall,
	input  dfvr_pkg::res_t                     res_data,
	input  wire logic                          cfg_we,
	input  wire logic [dfvr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [dfvr_pkg::CoefW-1:0]    cfg_wdata,
	output int                                 fail_count,
	output int                                 pending_count
);
	import dfvr_pkg::*;

	localparam longint Q14_ONE = 16384;

	logic signed [15:0] zdir [3];
	logic signed [15:0] xdir [3];
	logic               given_mode;
	longint             frame [9];
	logic               frame_valid;
	logic               frame_bad;
	res_t               rotated_q [$];

	assign pending_count = rotated_q.size();

	function automatic longint round_shift14(longint v);
		if (v >= 0)
			return (v + 8192) >>> 14;
		return -((-v + 8192) >>> 14);
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// scale to Q1.14 unit length, false on a zero vector
	function automatic bit unit_vec(input longint c [3], output longint o [3]);
		longint unsigned len2, s, m, q;
		len2 = 0;
		for (int i = 0; i < 3; i++)
			len2 += c[i] * c[i];
		o = '{0, 0, 0};
		if (len2 == 0)
			return 0;
		s = int_sqrt(len2 << 28);
		for (int i = 0; i < 3; i++) begin
			m = c[i] < 0 ? -c[i] : c[i];
			q = ((m << 28) + (s >> 1)) / s;
			if (q > Q14_ONE)
				q = Q14_ONE;
			o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	task automatic rebuild_frame();
		longint zr [3], xr [3], z [3], x [3];
		bit ok;
		for (int i = 0; i < 3; i++) begin
			zr[i] = zdir[i];
			xr[i] = xdir[i];
		end
		x = '{0, 0, 0};
		ok = unit_vec(zr, z);
		if (ok) begin
			if (given_mode)
				ok = unit_vec(xr, x);
			else if (z[0] == 0 && z[1] == 0)
				x = '{z[2], 0, 0};
			else begin
				xr = '{-z[1], z[0], 0};
				ok = unit_vec(xr, x);
			end
		end
		if (!ok) begin
			for (int i = 0; i < 9; i++)
				frame[i] = 0;
			frame_bad = 1;
		end else begin
			frame[0] = x[0];
			frame[1] = x[1];
			frame[2] = x[2];
			frame[3] = limit(round_shift14(z[1] * x[2] - z[2] * x[1]), -32768, 32767);
			frame[4] = limit(round_shift14(z[2] * x[0] - z[0] * x[2]), -32768, 32767);
			frame[5] = limit(round_shift14(z[0] * x[1] - z[1] * x[0]), -32768, 32767);
			frame[6] = z[0];
			frame[7] = z[1];
			frame[8] = z[2];
			frame_bad = 0;
		end
		frame_valid = 1;
	endtask

	function automatic res_t rotate_point(pos_t p);
		res_t r;
		longint pv [3];
		longint acc;
		pv[0] = p.pos_x;
		pv[1] = p.pos_y;
		pv[2] = p.pos_z;
		r = '0;
		for (int row = 0; row < 3; row++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += pv[k] * frame[k * 3 + row];
			acc = limit(round_shift14(acc), -8388608, 8388607);
			case (row)
				0: r.out_x = acc[23:0];
				1: r.out_y = acc[23:0];
				default: r.out_z = acc[23:0];
			endcase
		end
		r.degenerate = frame_bad;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			zdir = '{0, 0, 1};
			xdir = '{1, 0, 0};
			given_mode = 0;
			for (int i = 0; i < 9; i++)
				frame[i] = 0;
			frame_valid = 0;
			frame_bad = 0;
			rotated_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_Z_DIR_X: zdir[0] = cfg_wdata;
					REG_Z_DIR_Y: zdir[1] = cfg_wdata;
					REG_Z_DIR_Z: zdir[2] = cfg_wdata;
					REG_X_DIR_X: xdir[0] = cfg_wdata;
					REG_X_DIR_Y: xdir[1] = cfg_wdata;
					REG_X_DIR_Z: xdir[2] = cfg_wdata;
					REG_FRAME_MODE: given_mode = cfg_wdata[0];
					default: ;
				endcase
				if (cfg_index <= REG_FRAME_MODE)
					frame_valid = 0;
			end
			if (pos_valid && !pos_stall) begin
				if (!frame_valid)
					rebuild_frame();
				rotated_q = {rotated_q, rotate_point(pos_data)};
			end
			if (res_valid && !res_stall) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res_data);
					fail_count++;
				end else begin
					want = rotated_q.pop_front();
					if (res_data.out_x !== want.out_x) begin
						$display("%0t: out_x expected %h actual %h", $time, want.out_x,
							res_data.out_x);
						fail_count++;
					end
					if (res_data.out_y !== want.out_y) begin
						$display("%0t: out_y expected %h actual %h", $time, want.out_y,
							res_data.out_y);
						fail_count++;
					end
					if (res_data.out_z !== want.out_z) begin
						$display("%0t: out_z expected %h actual %h", $time, want.out_z,
							res_data.out_z);
						fail_count++;
					end
					if (res_data.degenerate !== want.degenerate) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degenerate, res_data.degenerate);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_direction_frame_vertex_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direction_frame_vertex_rotate
// Drives points through several frame settings with random idle and stall
// patterns and a long receiver hold-off; the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_direction_frame_vertex_rotate;
	import dfvr_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                pos_valid;
	logic                pos_stall;
	pos_t                pos_data;
	logic                res_valid;
	logic                res_stall;
	res_t                res_data;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CoefW-1:0]    cfg_wdata;
	int                  fail_count;
	int                  pending_count;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	bit                  hold_off;

	direction_frame_vertex_rotate dut (
		.clk(clk), .arst_n(arst_n),
		.pos_valid(pos_valid), .pos_stall(pos_stall), .pos_data(pos_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	dfvr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.pos_valid(pos_valid), .pos_stall(pos_stall), .pos_data(pos_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_direction_frame_vertex_rotate: errors");
		$finish;
	end

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off)
			res_stall <= 1;
		else
			res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(7))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($signed($urandom_range(8192)) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_point(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			pos_valid <= 0;
			@(posedge clk);
		end
		pos_valid <= 1;
		pos_data <= '{pos_x: px, pos_y: py, pos_z: pz};
		do
			@(posedge clk);
		while (pos_stall);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_frame(logic [15:0] zx, logic [15:0] zy, logic [15:0] zz,
		logic [15:0] xx, logic [15:0] xy, logic [15:0] xz, logic mode);
		pos_valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(REG_Z_DIR_X, zx);
		write_reg(REG_Z_DIR_Y, zy);
		write_reg(REG_Z_DIR_Z, zz);
		write_reg(REG_X_DIR_X, xx);
		write_reg(REG_X_DIR_Y, xy);
		write_reg(REG_X_DIR_Z, xz);
		write_reg(REG_FRAME_MODE, {15'd0, mode});
		// out-of-range index is ignored
		write_reg(3'd7, 16'($urandom));
	endtask

	function automatic logic [15:0] rand_dir();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(6)) - 3);
			3: return 16'd0;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [23:0] edge_vals [4];
		edge_vals = '{24'h7fffff, 24'h800000, 24'h000000, 24'hffffff};
		arst_n = 0;
		pos_valid = 0;
		pos_data = '0;
		res_stall = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset frame: identity
		for (int i = 0; i < 4; i++)
			send_point(edge_vals[i], edge_vals[3 - i], edge_vals[(i + 1) % 4]);
		send_point(24'h001000, 24'h002000, 24'hfff000);
		// z along z axis negative
		set_frame(16'd0, 16'd0, 16'h8000, 16'd1, 16'd0, 16'd0, 1'b0);
		send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_point(24'h800000, 24'h800000, 24'h800000);
		// general derive
		set_frame(16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'd0, 16'd0, 1'b0);
		send_point(24'h7fffff, 24'h800000, 24'h7fffff);
		send_point(24'h012345, 24'hfedcba, 24'h000777);
		// zero z
		set_frame(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 1'b0);
		send_point(24'h001000, 24'h001000, 24'h001000);
		// given mode, zero x
		set_frame(16'd3, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		send_point(24'h001000, 24'h002000, 24'h003000);
		// given mode, non-orthogonal x
		set_frame(16'd1, 16'd0, 16'd0, 16'hffff, 16'h7fff, 16'h8000, 1'b1);
		send_point(24'h7fffff, 24'h800000, 24'h400000);
		send_point(24'h123456, 24'h654321, 24'hababab);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			set_frame(rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir(),
				rand_dir(), 1'($urandom));
			if (ph == 4) begin
				fork
					begin
						hold_off = 1;
						repeat (200) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int n = 0; n < 125; n++)
				send_point(rand_coord(), rand_coord(), rand_coord());
		end
		pos_valid <= 0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_direction_frame_vertex_rotate: clean");
		else
			$display("tb_direction_frame_vertex_rotate: errors");
		$finish;
	end

endmodule

`default_nettype wire
